[src/rgb_to_cmyk_pixel_top_defines.svh]
// assertion helpers for the top-level rtl file
`ifndef RGB_TO_CMYK_PIXEL_TOP_DEFINES_SVH
`define RGB_TO_CMYK_PIXEL_TOP_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define RTCP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define RTCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rtcp_pkg.sv]
`default_nettype none

package rtcp_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int REM_W        = 2 * CHANNEL_BITS + 1;
  localparam int DSH_W        = 2 * CHANNEL_BITS;
  localparam int CFG_W        = 16;
  localparam int PROD_W       = 2 * CHANNEL_BITS;
  localparam int CMP_W        = (PROD_W > CFG_W) ? PROD_W : CFG_W;
  localparam int NUM_CH       = 3;

  localparam logic [CHANNEL_BITS-1:0] FULL = {CHANNEL_BITS{1'b1}};
  localparam logic [CFG_W-1:0] THRESH_RESET = 16'd16256;

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  // one pixel in flight through the divider chain
  typedef struct packed {
    logic [NUM_CH-1:0][REM_W-1:0]        rem;
    logic [NUM_CH-1:0][CHANNEL_BITS-1:0] quo;
    logic [DSH_W-1:0]                    dsh;
    chan_t                               key;
  } stage_t;

endpackage

`default_nettype wire

[src/rtcp_front.sv]
`default_nettype none

module rtcp_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  up_valid,
  output logic                 up_ready,
  input  wire rtcp_pkg::chan_t red,
  input  wire rtcp_pkg::chan_t green,
  input  wire rtcp_pkg::chan_t blue,
  output logic                 dn_valid,
  input  wire                  dn_ready,
  output rtcp_pkg::stage_t     dn_data
);
  import rtcp_pkg::*;

  chan_t                          ch [NUM_CH];
  chan_t                          max_ch;
  logic [REM_W-1:0]               diff_ext;
  logic [REM_W-1:0]               max_ext;
  stage_t                         data_nxt;
  stage_t                         data_r;
  logic                           valid_r;

  assign ch[0] = red;
  assign ch[1] = green;
  assign ch[2] = blue;

  always_comb begin
    max_ch = red;
    if (green > max_ch) begin
      max_ch = green;
    end
    if (blue > max_ch) begin
      max_ch = blue;
    end
  end

  // numerator (m - ch) * 2 * FULL + m, divisor 2m pre-shifted to the top step
  always_comb begin
    data_nxt = '0;
    diff_ext = '0;
    max_ext  = REM_W'(max_ch);
    for (int j = 0; j < NUM_CH; j++) begin
      diff_ext = REM_W'(max_ch - ch[j]);
      data_nxt.rem[j] = (diff_ext << (CHANNEL_BITS + 1)) - (diff_ext << 1) + max_ext;
    end
    data_nxt.dsh = {max_ch, {CHANNEL_BITS{1'b0}}};
    data_nxt.key = FULL - max_ch;
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

[src/rtcp_cell.sv]
`default_nettype none

module rtcp_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  up_valid,
  output logic                 up_ready,
  input  wire rtcp_pkg::stage_t up_data,
  output logic                 dn_valid,
  input  wire                  dn_ready,
  output rtcp_pkg::stage_t     dn_data
);
  import rtcp_pkg::*;

  logic [NUM_CH-1:0] ge;
  logic [REM_W-1:0]  dsh_ext;
  stage_t            data_nxt;
  stage_t            data_r;
  logic              valid_r;

  // one restoring step for all three channels, shared divisor
  always_comb begin
    data_nxt = up_data;
    dsh_ext  = REM_W'(up_data.dsh);
    for (int j = 0; j < NUM_CH; j++) begin
      ge[j] = up_data.rem[j] >= dsh_ext;
      data_nxt.rem[j] = ge[j] ? (up_data.rem[j] - dsh_ext) : up_data.rem[j];
      data_nxt.quo[j] = {up_data.quo[j][CHANNEL_BITS-2:0], ge[j]};
    end
    data_nxt.dsh = up_data.dsh >> 1;
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

[src/rtcp_back.sv]
`default_nettype none

module rtcp_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          up_valid,
  output logic                         up_ready,
  input  wire rtcp_pkg::stage_t        up_data,
  input  wire [rtcp_pkg::CFG_W-1:0]    threshold,
  output logic                         dn_valid,
  input  wire                          dn_ready,
  output rtcp_pkg::chan_t              cyan,
  output rtcp_pkg::chan_t              magenta,
  output rtcp_pkg::chan_t              yellow,
  output rtcp_pkg::chan_t              key,
  output logic                         mask
);
  import rtcp_pkg::*;

  logic              black;
  chan_t             cyan_nxt, magenta_nxt, yellow_nxt;
  logic [PROD_W-1:0] prod;
  logic              mask_nxt;
  chan_t             cyan_r, magenta_r, yellow_r, key_r;
  logic              mask_r;
  logic              valid_r;

  // m == 0 shows up as key == FULL; the divider output is garbage there
  assign black       = up_data.key == FULL;
  assign cyan_nxt    = black ? '0 : up_data.quo[0];
  assign magenta_nxt = black ? '0 : up_data.quo[1];
  assign yellow_nxt  = black ? '0 : up_data.quo[2];
  assign prod        = PROD_W'(up_data.key) * PROD_W'(FULL - magenta_nxt);
  assign mask_nxt    = CMP_W'(prod) > CMP_W'(threshold);

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign cyan     = cyan_r;
  assign magenta  = magenta_r;
  assign yellow   = yellow_r;
  assign key      = key_r;
  assign mask     = mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      cyan_r    <= cyan_nxt;
      magenta_r <= magenta_nxt;
      yellow_r  <= yellow_nxt;
      key_r     <= up_data.key;
      mask_r    <= mask_nxt;
    end
  end

endmodule

`default_nettype wire

[src/rgb_to_cmyk_pixel_top.sv]
`default_nettype none

// rgb to cmyk converter. one pixel enters per clock while the output is not stalled;
// each result is registered in the front stage (max, key and numerators), then
// once per quotient bit in the row of eight restoring divider cells, then in the
// back stage (black-pixel fixup and mask compare).
// cyan, magenta and yellow are round((m - ch) * 255 / m) with halves rounded up,
// key is 255 - m, and a black pixel gives zero cmy. mask is set when
// key * (255 - magenta) exceeds cfg mask_threshold (reset 16256); write the
// threshold only while no transaction is in flight.
module rgb_to_cmyk_pixel_top (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire [rtcp_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire rtcp_pkg::chan_t         in_red,
  input  wire rtcp_pkg::chan_t         in_green,
  input  wire rtcp_pkg::chan_t         in_blue,
  output logic                         out_valid,
  input  wire                          out_ready,
  output rtcp_pkg::chan_t              out_cyan,
  output rtcp_pkg::chan_t              out_magenta,
  output rtcp_pkg::chan_t              out_yellow,
  output rtcp_pkg::chan_t              out_key,
  output logic                         out_mask
);
  import rtcp_pkg::*;
  `include "rgb_to_cmyk_pixel_top_defines.svh"

  logic [CFG_W-1:0]      thresh_r;
  logic [CHANNEL_BITS:0] vld;
  logic [CHANNEL_BITS:0] rdy;
  stage_t                dat [CHANNEL_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_we) begin
      thresh_r <= cfg_wdata;
    end
  end

  rtcp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .red      (in_red),
    .green    (in_green),
    .blue     (in_blue),
    .dn_valid (vld[0]),
    .dn_ready (rdy[0]),
    .dn_data  (dat[0])
  );

  for (genvar i = 0; i < CHANNEL_BITS; i++) begin : g_cell
    rtcp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[i]),
      .up_ready (rdy[i]),
      .up_data  (dat[i]),
      .dn_valid (vld[i+1]),
      .dn_ready (rdy[i+1]),
      .dn_data  (dat[i+1])
    );
  end

  rtcp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (vld[CHANNEL_BITS]),
    .up_ready  (rdy[CHANNEL_BITS]),
    .up_data   (dat[CHANNEL_BITS]),
    .threshold (thresh_r),
    .dn_valid  (out_valid),
    .dn_ready  (out_ready),
    .cyan      (out_cyan),
    .magenta   (out_magenta),
    .yellow    (out_yellow),
    .key       (out_key),
    .mask      (out_mask)
  );

  // after the last step every remainder of a non-black pixel is below the divisor 2m
  `RTCP_ASSERT_IMPL(a_rem_below_div, vld[CHANNEL_BITS] && dat[CHANNEL_BITS].key != FULL,
    dat[CHANNEL_BITS].rem[0] < REM_W'({dat[CHANNEL_BITS].dsh, 1'b0}) &&
    dat[CHANNEL_BITS].rem[1] < REM_W'({dat[CHANNEL_BITS].dsh, 1'b0}) &&
    dat[CHANNEL_BITS].rem[2] < REM_W'({dat[CHANNEL_BITS].dsh, 1'b0}),
    "divider remainder out of range")
  `RTCP_ASSERT_IMPL(a_black_zero, out_valid && out_key == FULL,
    out_cyan == '0 && out_magenta == '0 && out_yellow == '0,
    "black pixel with nonzero cmy")
  `RTCP_ASSERT_IMPL(a_mask_needs_key, out_valid && out_mask, out_key != '0,
    "mask set with zero key")
  `RTCP_ASSERT_NEXT(a_front_hold, vld[0] && !rdy[0], vld[0] && $stable(dat[0]),
    "front stage lost or changed a stalled transaction")

endmodule

`default_nettype wire
